// ===== sv/task_slot_free_list_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler core.
`ifndef TASK_SLOT_FREE_LIST_SCHEDULER_CORE_DEFINES_SVH
`define TASK_SLOT_FREE_LIST_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSFLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSFLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tsfls_pkg.sv =====
package tsfls_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DONE   = 2'd1;
    localparam logic [OP_W-1:0] OP_YIELD  = 2'd2;
    localparam logic [OP_W-1:0] OP_RESUME = 2'd3;

    localparam logic [STATUS_W-1:0] SS_SUSPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] SS_RUNNING   = 2'd1;
    localparam logic [STATUS_W-1:0] SS_DONE      = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Control bundle from the sequencer to the slot memories.
    typedef struct packed {
        logic rd_en;
        logic wr_status_en;
        logic wr_link_en;
    } t_mem_ctl;

endpackage

// ===== sv/tsfls_if.sv =====
interface tsfls_in_if;
    import tsfls_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output op, output slot_index, input ready);
    modport sink   (input valid, input op, input slot_index, output ready);
endinterface

interface tsfls_out_if;
    import tsfls_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] live_count;

    modport source (output valid, output ok, output slot, output live_count, input ready);
    modport sink   (input valid, input ok, input slot, input live_count, output ready);
endinterface

// ===== sv/task_slot_free_list_scheduler_core.sv =====
// Task slot scheduler with a linked free list of released slots.
//
// Words arrive on i_req (op, slot_index) and one result word per request
// leaves on o_rsp (ok, slot, live_count); both use valid/ready and a word
// moves on a clock edge at which both are high.
// Create takes the head of the free list, or else the next never-used slot.
// Done releases the current slot onto the free list, yield suspends it and
// resume runs a suspended slot that lies within the used range.
//
// The edge that accepts a request reads the slot memories, and the edge that
// ends its execute cycle writes them back and loads the result register, so
// o_rsp.valid rises with that edge. A new request is taken only once the
// block is back in idle, after the single read/modify/write pass through
// the synchronous slot memories for the last one has finished.
// While the result register still holds an untaken word, a request in
// flight waits in its execute cycle; a new request is taken as soon as the
// block is back in idle, even while the last result waits.
// Synchronous reset empties the free list, clears the current task and the
// used and live counts; the slot memories need no clearing, since no entry
// is read before it has been written.
module task_slot_free_list_scheduler_core #(
    parameter int SLOTS = tsfls_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsfls_in_if.sink    i_req,
    tsfls_out_if.source o_rsp
);
    import tsfls_pkg::*;
    `include "task_slot_free_list_scheduler_core_defines.svh"

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    // Sequencer state and the request held for its execute cycle.
    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [SLOT_W-1:0] r_idx;

    // Scheduler registers.
    logic          r_fh_valid, n_fh_valid;
    logic [IW-1:0] r_fh, n_fh;
    logic          r_cur_valid, n_cur_valid;
    logic [IW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_live, n_live;

    // Result register facing o_rsp.
    logic               r_out_valid, n_out_valid;
    logic               r_ok, n_ok;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [COUNT_W-1:0] r_live_out, n_live_out;

    // Memory access.
    t_mem_ctl            w_mem_ctl;
    logic [IW-1:0]       w_rd_addr;
    logic [IW-1:0]       w_wr_addr;
    logic [STATUS_W-1:0] w_wr_status;
    logic [IW:0]         w_wr_link;
    logic [STATUS_W-1:0] w_rd_status;
    logic [IW:0]         w_rd_link;

    logic w_accept;
    logic w_commit;
    logic w_idx_in_range;

    tsfls_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_ctl       (w_mem_ctl),
        .i_rd_addr   (w_rd_addr),
        .i_wr_addr   (w_wr_addr),
        .i_wr_status (w_wr_status),
        .i_wr_link   (w_wr_link),
        .o_rd_status (w_rd_status),
        .o_rd_link   (w_rd_link)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // The memory read is issued on acceptance: resume looks at the named
    // slot, create at the free-list head; the others ignore the data.
    assign w_rd_addr = (i_req.op == OP_RESUME) ? IW'(i_req.slot_index) : r_fh;

    // The execute cycle may finish only when the result register is free.
    assign w_commit = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    assign w_idx_in_range = CMPW'(r_idx) < CMPW'(r_used);

    always_comb begin
        n_state     = r_state;
        n_fh_valid  = r_fh_valid;
        n_fh        = r_fh;
        n_cur_valid = r_cur_valid;
        n_cur       = r_cur;
        n_used      = r_used;
        n_live      = r_live;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_ok        = r_ok;
        n_slot      = r_slot;
        n_live_out  = r_live_out;

        w_mem_ctl.rd_en        = w_accept;
        w_mem_ctl.wr_status_en = 1'b0;
        w_mem_ctl.wr_link_en   = 1'b0;
        w_wr_addr   = r_cur;
        w_wr_status = SS_SUSPENDED;
        w_wr_link   = {r_fh_valid, r_fh};

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_commit) begin
                    logic          ok;
                    logic [IW-1:0] s;
                    ok = 1'b0;
                    s  = '0;
                    case (r_op)
                        OP_CREATE: begin
                            if (r_fh_valid) begin
                                ok         = 1'b1;
                                s          = r_fh;
                                n_fh_valid = w_rd_link[IW];
                                n_fh       = w_rd_link[IW-1:0];
                            end else if (r_used < CW'(SLOTS)) begin
                                ok     = 1'b1;
                                s      = IW'(r_used);
                                n_used = r_used + 1'b1;
                            end
                            if (ok) begin
                                w_mem_ctl.wr_status_en = 1'b1;
                                w_wr_addr   = s;
                                w_wr_status = SS_SUSPENDED;
                                if (r_live < CW'(SLOTS)) begin
                                    n_live = r_live + 1'b1;
                                end
                            end
                        end
                        OP_DONE: begin
                            if (r_cur_valid) begin
                                ok = 1'b1;
                                s  = r_cur;
                                // Push the slot in front of the present head.
                                w_mem_ctl.wr_status_en = 1'b1;
                                w_mem_ctl.wr_link_en   = 1'b1;
                                w_wr_addr   = r_cur;
                                w_wr_status = SS_DONE;
                                w_wr_link   = {r_fh_valid, r_fh};
                                n_fh_valid  = 1'b1;
                                n_fh        = r_cur;
                                n_cur_valid = 1'b0;
                                n_cur       = '0;
                                if (r_live != '0) begin
                                    n_live = r_live - 1'b1;
                                end
                            end
                        end
                        OP_YIELD: begin
                            if (r_cur_valid) begin
                                ok = 1'b1;
                                s  = r_cur;
                                w_mem_ctl.wr_status_en = 1'b1;
                                w_wr_addr   = r_cur;
                                w_wr_status = SS_SUSPENDED;
                                n_cur_valid = 1'b0;
                                n_cur       = '0;
                            end
                        end
                        OP_RESUME: begin
                            if (w_idx_in_range && (w_rd_status == SS_SUSPENDED)) begin
                                ok = 1'b1;
                                s  = IW'(r_idx);
                                w_mem_ctl.wr_status_en = 1'b1;
                                w_wr_addr   = IW'(r_idx);
                                w_wr_status = SS_RUNNING;
                                n_cur_valid = 1'b1;
                                n_cur       = IW'(r_idx);
                            end
                        end
                        default: begin
                            ok = 1'b0;
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_ok        = ok;
                    n_slot      = ok ? SLOT_W'(s) : '0;
                    n_live_out  = COUNT_W'(n_live);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fh_valid  <= 1'b0;
            r_fh        <= '0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_used      <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fh_valid  <= n_fh_valid;
            r_fh        <= n_fh;
            r_cur_valid <= n_cur_valid;
            r_cur       <= n_cur;
            r_used      <= n_used;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.op;
            r_idx <= i_req.slot_index;
        end
        r_ok       <= n_ok;
        r_slot     <= n_slot;
        r_live_out <= n_live_out;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_ok;
    assign o_rsp.slot       = r_slot;
    assign o_rsp.live_count = r_live_out;

    // An accepted request always moves on to its execute cycle.
    `TSFLS_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept,
                       r_state == ST_EXEC, "accepted request did not enter execute")
    // Every live task occupies a slot that has been handed out.
    `TSFLS_ASSERT_NOW(a_live_le_used, i_clk, i_rst_n, 1'b1,
                      r_live <= r_used, "live count exceeds used slots")
    // The current task always lies within the used range.
    `TSFLS_ASSERT_NOW(a_cur_in_range, i_clk, i_rst_n, r_cur_valid,
                      CW'(r_cur) < r_used, "current slot outside used range")
    // A result word appears only as the end of an execute cycle.
    `TSFLS_ASSERT_NOW(a_result_from_exec, i_clk, i_rst_n, $rose(r_out_valid),
                      $past(r_state) == ST_EXEC, "result without execute cycle")

endmodule

// ===== sv/tsfls_slot_mem.sv =====
module tsfls_slot_mem #(
    parameter int SLOTS = tsfls_pkg::SLOTS_DEF,
    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                          i_clk,
    input  tsfls_pkg::t_mem_ctl           i_ctl,
    input  logic [IW-1:0]                 i_rd_addr,
    input  logic [IW-1:0]                 i_wr_addr,
    input  logic [tsfls_pkg::STATUS_W-1:0] i_wr_status,
    input  logic [IW:0]                   i_wr_link,
    output logic [tsfls_pkg::STATUS_W-1:0] o_rd_status,
    output logic [IW:0]                   o_rd_link
);
    import tsfls_pkg::*;

    // Status per slot, and a free-list link whose top bit marks a successor.
    logic [STATUS_W-1:0] status_mem [SLOTS];
    logic [IW:0]         link_mem   [SLOTS];

    logic [STATUS_W-1:0] r_rd_status;
    logic [IW:0]         r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_status_en) begin
            status_mem[i_wr_addr] <= i_wr_status;
        end
        if (i_ctl.wr_link_en) begin
            link_mem[i_wr_addr] <= i_wr_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_status <= status_mem[i_rd_addr];
            r_rd_link   <= link_mem[i_rd_addr];
        end
    end

    assign o_rd_status = r_rd_status;
    assign o_rd_link   = r_rd_link;

endmodule
